// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// when the trigger holds, the consequence holds in the next cycle
`define ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

// when the trigger holds, the consequence holds in the same cycle
`define ASSERT_IMPL(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

// ----- hdl/u8v_pkg.sv -----
// ----------------------------------------------------------------------------
// u8v_pkg
// types and constants shared by the utf-8 validator with mark detection
// ----------------------------------------------------------------------------
`default_nettype none

package u8v_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [1:0] pos_t;
	typedef logic [1:0] pend_t;

	typedef enum logic [1:0] {
		MARK_NONE    = 2'd0,
		MARK_UTF8    = 2'd1,
		MARK_UTF16LE = 2'd2,
		MARK_UTF16BE = 2'd3
	} mark_t;

	// lead and continuation byte classes
	localparam byte_t ASCII_MAX  = 8'h7F;
	localparam byte_t MASK_2B    = 8'hE0;
	localparam byte_t LEAD_2B    = 8'hC0;
	localparam byte_t MASK_3B    = 8'hF0;
	localparam byte_t LEAD_3B    = 8'hE0;
	localparam byte_t MASK_4B    = 8'hF8;
	localparam byte_t LEAD_4B    = 8'hF0;
	localparam byte_t MASK_CONT  = 8'hC0;
	localparam byte_t VAL_CONT   = 8'h80;

	// byte order mark bytes
	localparam byte_t BOM8_B0    = 8'hEF;
	localparam byte_t BOM8_B1    = 8'hBB;
	localparam byte_t BOM8_B2    = 8'hBF;
	localparam byte_t BOM_FF     = 8'hFF;
	localparam byte_t BOM_FE     = 8'hFE;

	localparam pos_t  POS_FIRST  = 2'd0;
	localparam pos_t  POS_SECOND = 2'd1;
	localparam pos_t  POS_THIRD  = 2'd2;
	localparam pos_t  POS_REST   = 2'd3;

	typedef struct packed {
		logic  utf8_ok;
		mark_t mark_kind;
	} result_t;

endpackage

`default_nettype wire

// ----- hdl/u8v_in_if.sv -----
// ----------------------------------------------------------------------------
// u8v_in_if
// byte channel into the validator: valid, ready, byte and end flag
// ----------------------------------------------------------------------------
`default_nettype none

interface u8v_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_buffer;

	modport source (output valid, output text_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input text_byte, input end_of_buffer, output ready);

endinterface

`default_nettype wire

// ----- hdl/u8v_out_if.sv -----
// ----------------------------------------------------------------------------
// u8v_out_if
// result channel out of the validator: valid, ready, verdict and mark kind
// ----------------------------------------------------------------------------
`default_nettype none

interface u8v_out_if;

	logic       valid;
	logic       ready;
	logic       utf8_ok;
	logic [1:0] mark_kind;

	modport source (output valid, output utf8_ok, output mark_kind, input ready);
	modport sink   (input valid, input utf8_ok, input mark_kind, output ready);

endinterface

`default_nettype wire

// ----- hdl/utf8_stream_validator_bom_core.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_bom_core
// structural utf-8 check of a byte buffer with byte order mark detection
// ----------------------------------------------------------------------------
//   port    dir   payload                       handshake
//   text    sink  text_byte[7:0], end_of_buffer valid/ready
//   result  src   utf8_ok, mark_kind[1:0]       valid/ready
//
// one byte per cycle while no final byte waits on a stalled result; the final
// byte passes the input register, then the result register
// reset clears the input stage, the buffer state and the result register
// a stalled result holds the input stage only when it carries a final byte;
// other bytes keep flowing behind a waiting result
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module utf8_stream_validator_bom_core (
	input  logic      clk,
	input  logic      arst_n,
	u8v_in_if.sink    text,
	u8v_out_if.source result
);

	logic             valid_s1;
	u8v_pkg::byte_t   byte_s1;
	logic             last_s1;
	logic             advance;
	logic             can_load;
	u8v_pkg::result_t step_res;

	assign advance    = valid_s1 && (!last_s1 || can_load);
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.end_of_buffer;
		end
	end

	u8v_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.text_byte     (byte_s1),
		.end_of_buffer (last_s1),
		.result        (step_res)
	);

	u8v_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.result   (step_res),
		.can_load (can_load),
		.out      (result)
	);

	`ASSERT_IMPL(a_stall_cause, valid_s1 && !advance,
		last_s1 && result.valid && !result.ready,
		"input stage stalled without a blocked result")
	`ASSERT_NEXT(a_hold_stalled, valid_s1 && !advance,
		valid_s1 && $stable(byte_s1) && $stable(last_s1), "stalled byte lost")

endmodule

`default_nettype wire

// ----- hdl/u8v_step.sv -----
// ----------------------------------------------------------------------------
// u8v_step
// per-buffer state and the single-byte update: mark capture and utf-8 check
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8v_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  u8v_pkg::byte_t    text_byte,
	input  logic              end_of_buffer,
	output u8v_pkg::result_t  result
);

	u8v_pkg::pos_t  pos_q,   pos_d;
	u8v_pkg::byte_t b0_q,    b0_d;
	u8v_pkg::byte_t b1_q,    b1_d;
	u8v_pkg::pend_t pend_q,  pend_d;
	logic           err_q,   err_d;
	u8v_pkg::mark_t mark_q,  mark_d;

	always_comb begin
		pos_d  = pos_q;
		b0_d   = b0_q;
		b1_d   = b1_q;
		pend_d = pend_q;
		err_d  = err_q;
		mark_d = mark_q;

		// marks live in the first three bytes only
		case (pos_q)
			u8v_pkg::POS_FIRST: begin
				b0_d = text_byte;
			end
			u8v_pkg::POS_SECOND: begin
				b1_d = text_byte;
				if (b0_q == u8v_pkg::BOM_FF && text_byte == u8v_pkg::BOM_FE) begin
					mark_d = u8v_pkg::MARK_UTF16LE;
				end else if (b0_q == u8v_pkg::BOM_FE && text_byte == u8v_pkg::BOM_FF) begin
					mark_d = u8v_pkg::MARK_UTF16BE;
				end
			end
			u8v_pkg::POS_THIRD: begin
				if (b0_q == u8v_pkg::BOM8_B0 && b1_q == u8v_pkg::BOM8_B1 &&
				    text_byte == u8v_pkg::BOM8_B2) begin
					mark_d = u8v_pkg::MARK_UTF8;
				end
			end
			default: begin
			end
		endcase
		if (pos_q != u8v_pkg::POS_REST) begin
			pos_d = pos_q + 2'd1;
		end

		// structural check
		if (pend_q != 2'd0) begin
			if ((text_byte & u8v_pkg::MASK_CONT) != u8v_pkg::VAL_CONT) begin
				err_d = 1'b1;
			end
			pend_d = pend_q - 2'd1;
		end else if (text_byte inside {[8'h00 : u8v_pkg::ASCII_MAX]}) begin
			pend_d = 2'd0;
		end else if ((text_byte & u8v_pkg::MASK_2B) == u8v_pkg::LEAD_2B) begin
			pend_d = 2'd1;
		end else if ((text_byte & u8v_pkg::MASK_3B) == u8v_pkg::LEAD_3B) begin
			pend_d = 2'd2;
		end else if ((text_byte & u8v_pkg::MASK_4B) == u8v_pkg::LEAD_4B) begin
			pend_d = 2'd3;
		end else begin
			err_d = 1'b1;
		end
	end

	assign result.utf8_ok   = (mark_d == u8v_pkg::MARK_UTF8) || (!err_d && pend_d == 2'd0);
	assign result.mark_kind = mark_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= u8v_pkg::POS_FIRST;
			b0_q   <= '0;
			b1_q   <= '0;
			pend_q <= '0;
			err_q  <= 1'b0;
			mark_q <= u8v_pkg::MARK_NONE;
		end else if (advance) begin
			if (end_of_buffer) begin
				// back to the reset state for the next buffer
				pos_q  <= u8v_pkg::POS_FIRST;
				b0_q   <= '0;
				b1_q   <= '0;
				pend_q <= '0;
				err_q  <= 1'b0;
				mark_q <= u8v_pkg::MARK_NONE;
			end else begin
				pos_q  <= pos_d;
				b0_q   <= b0_d;
				b1_q   <= b1_d;
				pend_q <= pend_d;
				err_q  <= err_d;
				mark_q <= mark_d;
			end
		end
	end

	`ASSERT_NEXT(a_clear_after_end, advance && end_of_buffer, pos_q == u8v_pkg::POS_FIRST && pend_q == 2'd0 && !err_q && mark_q == u8v_pkg::MARK_NONE, "state not cleared after final byte")
	`ASSERT_IMPL(a_utf8_mark_pos, mark_q == u8v_pkg::MARK_UTF8, pos_q == u8v_pkg::POS_REST, "utf-8 mark before third byte")
	`ASSERT_IMPL(a_utf16_mark_pos, mark_q == u8v_pkg::MARK_UTF16LE || mark_q == u8v_pkg::MARK_UTF16BE, pos_q == u8v_pkg::POS_THIRD || pos_q == u8v_pkg::POS_REST, "utf-16 mark before second byte")

endmodule

`default_nettype wire

// ----- hdl/u8v_out_reg.sv -----
// ----------------------------------------------------------------------------
// u8v_out_reg
// result register driving the output channel, holds a word under stall
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module u8v_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  u8v_pkg::result_t  result,
	output logic              can_load,
	u8v_out_if.source         out
);

	logic             valid_q;
	u8v_pkg::result_t data_q;

	assign can_load = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= result;
		end
	end

	assign out.valid     = valid_q;
	assign out.utf8_ok   = data_q.utf8_ok;
	assign out.mark_kind = data_q.mark_kind;

	`ASSERT_IMPL(a_no_overwrite, load && valid_q && !out.ready, !can_load, "result overwritten while stalled")

endmodule

`default_nettype wire

// ----- bench/utf8_stream_validator_bom_core_tb.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_bom_core_tb
// self-checking bench for the utf-8 validator with byte order mark detection:
// a directed table of short buffers, then random buffers (well-formed text,
// marks, corrupted and cut-off sequences, noise). Every taken word runs
// through a local scanner that predicts the verdict. Words are sent in bursts
// with gaps, and the result side stalls on rotating patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator_bom_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD  = 12;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_WORDS = 1900;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 10;
	localparam int SHOW_FAULTS  = 10;

	typedef struct {
		u8v_pkg::byte_t b;
		logic           last;
		logic           typed;
		logic           want_ok;
		u8v_pkg::mark_t want_mark;
	} word_t;

	// short buffers; verdicts typed in where they are plain to see
	word_t directed_rows [24] = '{
		'{8'h00, 1'b1, 1'b1, 1'b1, u8v_pkg::MARK_NONE},
		'{8'hFF, 1'b1, 1'b1, 1'b0, u8v_pkg::MARK_NONE},
		'{8'h80, 1'b1, 1'b1, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hFF, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hFE, 1'b1, 1'b1, 1'b0, u8v_pkg::MARK_UTF16LE},
		'{8'hFE, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hFF, 1'b1, 1'b1, 1'b0, u8v_pkg::MARK_UTF16BE},
		'{8'hEF, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hBB, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hBF, 1'b1, 1'b1, 1'b1, u8v_pkg::MARK_UTF8},
		'{8'hEF, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hBB, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hBF, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hFF, 1'b1, 1'b1, 1'b1, u8v_pkg::MARK_UTF8},
		'{8'hEF, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hBB, 1'b1, 1'b1, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hF0, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'h9F, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'h98, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'h80, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'h41, 1'b1, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hC3, 1'b0, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'h41, 1'b1, 1'b0, 1'b0, u8v_pkg::MARK_NONE},
		'{8'hF8, 1'b1, 1'b1, 1'b0, u8v_pkg::MARK_NONE}
	};

	logic clk;
	logic arst_n;

	u8v_in_if  text_if ();
	u8v_out_if result_if ();

	utf8_stream_validator_bom_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_if),
		.result (result_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	word_t            word_q [$];
	u8v_pkg::byte_t   buf_q [$];
	u8v_pkg::result_t verdict_q [$];
	int               n_words;
	int               send_idx;
	int               accept_idx;
	int               fault_count;
	int               cycle_count;
	int               n_results;
	int               n_valid;
	int               mark_count [4];
	logic             text_taken;

	// scanner state
	u8v_pkg::pos_t  scan_pos;
	u8v_pkg::byte_t head_bytes [2];
	u8v_pkg::pend_t cont_left;
	logic           bad_seq;
	u8v_pkg::mark_t found_mark;

	function automatic logic scan_byte(input u8v_pkg::byte_t b, input logic last,
		output u8v_pkg::result_t verdict);
		verdict = '0;
		case (scan_pos)
			u8v_pkg::POS_FIRST: head_bytes[0] = b;
			u8v_pkg::POS_SECOND: begin
				head_bytes[1] = b;
				if (head_bytes[0] == u8v_pkg::BOM_FF && b == u8v_pkg::BOM_FE)
					found_mark = u8v_pkg::MARK_UTF16LE;
				else if (head_bytes[0] == u8v_pkg::BOM_FE && b == u8v_pkg::BOM_FF)
					found_mark = u8v_pkg::MARK_UTF16BE;
			end
			u8v_pkg::POS_THIRD: begin
				if (head_bytes[0] == u8v_pkg::BOM8_B0 &&
					head_bytes[1] == u8v_pkg::BOM8_B1 && b == u8v_pkg::BOM8_B2)
					found_mark = u8v_pkg::MARK_UTF8;
			end
			default: ;
		endcase
		if (scan_pos != u8v_pkg::POS_REST)
			scan_pos = scan_pos + u8v_pkg::pos_t'(1);

		if (cont_left != u8v_pkg::pend_t'(0)) begin
			if ((b & u8v_pkg::MASK_CONT) != u8v_pkg::VAL_CONT)
				bad_seq = 1'b1;
			cont_left = cont_left - u8v_pkg::pend_t'(1);
		end else if (b <= u8v_pkg::ASCII_MAX) begin
			cont_left = u8v_pkg::pend_t'(0);
		end else if ((b & u8v_pkg::MASK_2B) == u8v_pkg::LEAD_2B) begin
			cont_left = u8v_pkg::pend_t'(1);
		end else if ((b & u8v_pkg::MASK_3B) == u8v_pkg::LEAD_3B) begin
			cont_left = u8v_pkg::pend_t'(2);
		end else if ((b & u8v_pkg::MASK_4B) == u8v_pkg::LEAD_4B) begin
			cont_left = u8v_pkg::pend_t'(3);
		end else begin
			bad_seq = 1'b1;
		end

		if (!last)
			return 1'b0;
		verdict.utf8_ok   = (found_mark == u8v_pkg::MARK_UTF8) ||
			(!bad_seq && cont_left == u8v_pkg::pend_t'(0));
		verdict.mark_kind = found_mark;
		scan_pos      = u8v_pkg::POS_FIRST;
		head_bytes[0] = '0;
		head_bytes[1] = '0;
		cont_left     = '0;
		bad_seq       = 1'b0;
		found_mark    = u8v_pkg::MARK_NONE;
		return 1'b1;
	endfunction

	// one well-formed character of 1 to 4 bytes with random payload
	task automatic push_char();
		int len;
		len = $urandom_range(1, 4);
		case (len)
			1: buf_q.push_back(u8v_pkg::byte_t'($urandom_range(0, 127)));
			2: buf_q.push_back(u8v_pkg::LEAD_2B | u8v_pkg::byte_t'($urandom_range(0, 31)));
			3: buf_q.push_back(u8v_pkg::LEAD_3B | u8v_pkg::byte_t'($urandom_range(0, 15)));
			default: buf_q.push_back(u8v_pkg::LEAD_4B |
				u8v_pkg::byte_t'($urandom_range(0, 7)));
		endcase
		repeat (len - 1)
			buf_q.push_back(u8v_pkg::VAL_CONT | u8v_pkg::byte_t'($urandom_range(0, 63)));
	endtask

	task automatic log_fault(input string what, input u8v_pkg::result_t want,
		input logic got_ok, input logic [1:0] got_mark);
		fault_count++;
		if (fault_count <= SHOW_FAULTS)
			$display("%0t: %s: expected ok=%0b mark=%0d, got ok=%0b mark=%0d",
				$realtime, what, want.utf8_ok, want.mark_kind, got_ok, got_mark);
	endtask

	// sender: bursts of words with random gaps, stimulus changes on the falling edge
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (arst_n && (!text_if.valid || text_taken)) begin
			if (gap_left > 0 || send_idx >= n_words) begin
				if (gap_left > 0)
					gap_left--;
				text_if.valid <= 1'b0;
			end else begin
				text_if.valid         <= 1'b1;
				text_if.text_byte     <= word_q[send_idx].b;
				text_if.end_of_buffer <= word_q[send_idx].last;
				send_idx++;
				if (burst_left > 1) begin
					burst_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					// long stretch with no idling
					burst_left = $urandom_range(50, 200);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left   = $urandom_range(0, 12);
				end
			end
		end
	end

	// receiver: ready follows a rotating pattern that is swapped now and then
	logic [15:0] stall_pat = 16'hFFFF;
	int          pat_left  = 0;

	always @(negedge clk) begin
		if (pat_left == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pat = 16'hFFFF;
				1: stall_pat = 16'($urandom) | 16'h8000;
				2: stall_pat = 16'h0001; // long stalls
				default: stall_pat = 16'hAAAA;
			endcase
			pat_left = $urandom_range(50, 300);
		end else begin
			pat_left--;
		end
		stall_pat = {stall_pat[0], stall_pat[15:1]};
		result_if.ready <= stall_pat[0];
	end

	// monitor: predict on every taken word, check every taken result
	always @(posedge clk) begin : monitor
		u8v_pkg::result_t verdict;
		u8v_pkg::result_t want;
		text_taken <= arst_n && text_if.valid && text_if.ready;
		if (arst_n) begin
			if (text_if.valid && text_if.ready) begin
				if (scan_byte(text_if.text_byte, text_if.end_of_buffer, verdict)) begin
					if (word_q[accept_idx].typed) begin
						verdict.utf8_ok   = word_q[accept_idx].want_ok;
						verdict.mark_kind = word_q[accept_idx].want_mark;
					end
					verdict_q.push_back(verdict);
				end
				accept_idx++;
			end
			if (result_if.valid && result_if.ready) begin
				if (verdict_q.size() == 0) begin
					log_fault("result with no verdict pending", '0, result_if.utf8_ok,
						result_if.mark_kind);
				end else begin
					want = verdict_q.pop_front();
					n_results++;
					n_valid += want.utf8_ok;
					mark_count[want.mark_kind]++;
					if (result_if.utf8_ok !== want.utf8_ok ||
						result_if.mark_kind !== want.mark_kind)
						log_fault("verdict mismatch", want, result_if.utf8_ok,
							result_if.mark_kind);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d words taken, %0d verdicts pending",
				cycle_count, accept_idx, n_words, verdict_q.size());
			$display("utf8_stream_validator_bom_core test failed");
			$finish;
		end
	end

	initial begin
		word_t w;
		int    pick;
		int    m;
		clk                   = 1'b0;
		arst_n                = 1'b0;
		text_if.valid         = 1'b0;
		text_if.text_byte     = '0;
		text_if.end_of_buffer = 1'b0;
		result_if.ready       = 1'b0;
		text_taken            = 1'b0;
		scan_pos              = u8v_pkg::POS_FIRST;
		head_bytes[0]         = '0;
		head_bytes[1]         = '0;
		cont_left             = '0;
		bad_seq               = 1'b0;
		found_mark            = u8v_pkg::MARK_NONE;
		foreach (mark_count[i])
			mark_count[i] = 0;

		foreach (directed_rows[i])
			word_q.push_back(directed_rows[i]);

		while (word_q.size() < RANDOM_WORDS + $size(directed_rows)) begin
			buf_q.delete();
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				m = $urandom_range(0, 9);
				if (m < 2) begin
					buf_q.push_back(u8v_pkg::BOM8_B0);
					buf_q.push_back(u8v_pkg::BOM8_B1);
					buf_q.push_back(u8v_pkg::BOM8_B2);
				end else if (m == 2) begin
					buf_q.push_back(u8v_pkg::BOM_FF);
					buf_q.push_back(u8v_pkg::BOM_FE);
				end else if (m == 3) begin
					buf_q.push_back(u8v_pkg::BOM_FE);
					buf_q.push_back(u8v_pkg::BOM_FF);
				end
				repeat ($urandom_range(m < 4 ? 0 : 1, 10))
					push_char();
				// broken buffers: a random byte somewhere, or a cut-off tail
				if (pick >= 60) begin
					if ($urandom_range(0, 1))
						buf_q[$urandom_range(0, buf_q.size() - 1)] =
							u8v_pkg::byte_t'($urandom_range(0, 255));
					else if (buf_q.size() > 1)
						void'(buf_q.pop_back());
				end
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 8))
					buf_q.push_back(u8v_pkg::byte_t'($urandom_range(0, 255)));
			end else begin
				// short buffers built mostly from mark bytes
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 5))
						0: buf_q.push_back(u8v_pkg::BOM8_B0);
						1: buf_q.push_back(u8v_pkg::BOM8_B1);
						2: buf_q.push_back(u8v_pkg::BOM8_B2);
						3: buf_q.push_back(u8v_pkg::BOM_FF);
						4: buf_q.push_back(u8v_pkg::BOM_FE);
						default: buf_q.push_back(u8v_pkg::byte_t'($urandom_range(0, 255)));
					endcase
				end
			end
			foreach (buf_q[k]) begin
				w.b         = buf_q[k];
				w.last      = (k == buf_q.size() - 1);
				w.typed     = 1'b0;
				w.want_ok   = 1'b0;
				w.want_mark = u8v_pkg::MARK_NONE;
				word_q.push_back(w);
			end
		end
		n_words = word_q.size();

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		while (accept_idx < n_words)
			@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words in %0d buffers checked, %0d judged valid", accept_idx,
			n_results, n_valid);
		$display("opening marks: none %0d, utf-8 %0d, utf-16le %0d, utf-16be %0d",
			mark_count[u8v_pkg::MARK_NONE], mark_count[u8v_pkg::MARK_UTF8],
			mark_count[u8v_pkg::MARK_UTF16LE], mark_count[u8v_pkg::MARK_UTF16BE]);
		if (fault_count == 0)
			$display("utf8_stream_validator_bom_core test passed");
		else
			$display("utf8_stream_validator_bom_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
